@@ rtl/rcpws_pkg.sv @@
`default_nettype none

package rcpws_pkg;

  // frame geometry
  localparam int unsigned CodeBits  = 24;
  localparam int unsigned GapUnits  = 31;
  localparam int unsigned LongUnits = 3;

  // configuration registers are fixed at 24 bits
  localparam int unsigned CfgW = 24;

  // index of the verification frame within one sequence
  localparam int unsigned FrameW    = 2;
  localparam int unsigned LastFrame = 2;

  localparam int unsigned BitPosW = $clog2(CodeBits + 1);
  localparam int unsigned UnitsW  = $clog2(((GapUnits > LongUnits) ? GapUnits : LongUnits) + 1);

  // stream field widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgIdxW  = 2;

  // request kinds
  localparam logic ReqStart = 1'b0;
  localparam logic ReqTick  = 1'b1;

  // command codes
  localparam logic [CmdW-1:0] CmdUp   = 2'd0;
  localparam logic [CmdW-1:0] CmdDown = 2'd1;
  localparam logic [CmdW-1:0] CmdStop = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgUpCode     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDownCode   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStopCode   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgVerifyCode = 2'd3;

  // reset values of the code words
  localparam logic [CfgW-1:0] UpCodeRst     = 24'h88EEFC;
  localparam logic [CfgW-1:0] DownCodeRst   = 24'h88EECF;
  localparam logic [CfgW-1:0] StopCodeRst   = 24'h88EEF3;
  localparam logic [CfgW-1:0] VerifyCodeRst = 24'h88EEFF;

  typedef struct packed {
    logic [CfgW-1:0] up_code;
    logic [CfgW-1:0] down_code;
    logic [CfgW-1:0] stop_code;
    logic [CfgW-1:0] verify_code;
  } codes_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic accepted;
  } seq_res_t;

endpackage

`default_nettype wire

@@ rtl/rcpws_cfg.sv @@
`default_nettype none

module rcpws_cfg
  import rcpws_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [CfgIdxW-1:0] wr_index_i,
  input  wire logic [CfgW-1:0]    wr_data_i,
  output codes_t                  codes_o
);

  codes_t codes_q;

  // code word registers, written by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.up_code     <= UpCodeRst;
      codes_q.down_code   <= DownCodeRst;
      codes_q.stop_code   <= StopCodeRst;
      codes_q.verify_code <= VerifyCodeRst;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CfgUpCode:     codes_q.up_code     <= wr_data_i;
        CfgDownCode:   codes_q.down_code   <= wr_data_i;
        CfgStopCode:   codes_q.stop_code   <= wr_data_i;
        CfgVerifyCode: codes_q.verify_code <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign codes_o = codes_q;

endmodule

`default_nettype wire

@@ rtl/rcpws_seq.sv @@
`default_nettype none

module rcpws_seq
  import rcpws_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            req_type_i,
  input  wire logic [CmdW-1:0] command_i,
  input  codes_t               codes_i,
  output seq_res_t             res_o
);

  typedef enum logic [1:0] {
    PhMark,
    PhSpace,
    PhEnd,
    PhGap
  } phase_e;

  logic                sending_q, sending_d;
  logic [FrameW-1:0]   frame_q, frame_d;
  logic [BitPosW-1:0]  bit_q, bit_d;
  phase_e              phase_q, phase_d;
  logic [UnitsW-1:0]   units_q, units_d;
  logic [CodeBits-1:0] shift_q, shift_d;
  logic [CfgW-1:0]     chosen_q, chosen_d;

  logic [CfgW-1:0]     sel_code;
  logic                cmd_ok;
  logic [UnitsW-1:0]   units_dec;
  logic [CodeBits-1:0] shifted;
  logic [FrameW-1:0]   frame_inc;
  logic [BitPosW-1:0]  bit_inc;
  logic [CodeBits-1:0] frame_word;

  // command word selection
  always_comb begin
    cmd_ok   = 1'b1;
    sel_code = codes_i.up_code;
    case (command_i)
      CmdUp:   sel_code = codes_i.up_code;
      CmdDown: sel_code = codes_i.down_code;
      CmdStop: sel_code = codes_i.stop_code;
      default: cmd_ok = 1'b0;
    endcase
  end

  assign units_dec  = (units_q != '0) ? units_q - 1'b1 : '0;
  assign shifted    = shift_q << 1;
  assign frame_inc  = frame_q + 1'b1;
  assign bit_inc    = bit_q + 1'b1;
  assign frame_word = (frame_inc >= FrameW'(LastFrame)) ? CodeBits'(codes_i.verify_code)
                                                        : CodeBits'(chosen_q);

  // next state for one item
  always_comb begin
    sending_d = sending_q;
    frame_d   = frame_q;
    bit_d     = bit_q;
    phase_d   = phase_q;
    units_d   = units_q;
    shift_d   = shift_q;
    chosen_d  = chosen_q;
    res_o     = '0;

    if (req_type_i == ReqStart) begin
      if (!sending_q && cmd_ok) begin
        chosen_d       = sel_code;
        sending_d      = 1'b1;
        frame_d        = '0;
        shift_d        = CodeBits'(sel_code);
        bit_d          = '0;
        phase_d        = PhMark;
        units_d        = shift_d[CodeBits-1] ? UnitsW'(1) : UnitsW'(LongUnits);
        res_o.accepted = 1'b1;
      end
    end else if (sending_q) begin
      res_o.carrier_on = (phase_q == PhMark) || (phase_q == PhEnd);
      units_d = units_dec;
      if (units_dec == '0) begin
        case (phase_q)
          PhMark: begin
            phase_d = PhSpace;
            units_d = shift_q[CodeBits-1] ? UnitsW'(LongUnits) : UnitsW'(1);
          end
          PhSpace: begin
            shift_d = shifted;
            bit_d   = bit_inc;
            if (bit_inc >= BitPosW'(CodeBits)) begin
              phase_d = PhEnd;
              units_d = UnitsW'(1);
            end else begin
              phase_d = PhMark;
              units_d = shifted[CodeBits-1] ? UnitsW'(1) : UnitsW'(LongUnits);
            end
          end
          PhEnd: begin
            if (frame_q < FrameW'(LastFrame)) begin
              phase_d = PhGap;
              units_d = UnitsW'(GapUnits);
            end else begin
              sending_d = 1'b0;
              frame_d   = '0;
              bit_d     = '0;
              phase_d   = PhMark;
              units_d   = '0;
              shift_d   = '0;
            end
          end
          default: begin
            // gap over: next frame starts
            frame_d = frame_inc;
            shift_d = frame_word;
            bit_d   = '0;
            phase_d = PhMark;
            units_d = frame_word[CodeBits-1] ? UnitsW'(1) : UnitsW'(LongUnits);
          end
        endcase
      end
    end

    res_o.busy_res = sending_d;
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      frame_q   <= '0;
      bit_q     <= '0;
      phase_q   <= PhMark;
      units_q   <= '0;
      shift_q   <= '0;
      chosen_q  <= '0;
    end else if (en_i) begin
      sending_q <= sending_d;
      frame_q   <= frame_d;
      bit_q     <= bit_d;
      phase_q   <= phase_d;
      units_q   <= units_d;
      shift_q   <= shift_d;
      chosen_q  <= chosen_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/remote_code_pulse_width_sender.sv @@
// Pulse-width remote code sender.
// Requests arrive on the s_axis channel: tuser says whether the request is a
// start (tuser 0, tdata carries the command: up, down or stop) or one tick of
// the time unit. A start is taken only while no sequence runs. Each tick then
// reports the carrier level for that unit and moves the sequence on: command
// frame, gap, command frame, gap, verification frame, each frame 24 bits MSB
// first plus an end mark.
// Every request gives exactly one result on m_axis: carrier level, busy flag
// after the request, and whether a start was taken.
// Code words are written through the cfg channel, which is always ready;
// write them only while the block is idle.
// A request passes through the input register, then the result register; one
// request per cycle is sustained while m_axis is ready, the sequencer update
// being a single short step per request.
// Reset clears the sequence to idle and loads the default code words.
// When m_axis stalls, the pending result holds and one further request is
// kept in the input register before s_axis_tready drops.
`default_nettype none

module remote_code_pulse_width_sender
  import rcpws_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // request stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [1:0] command
  input  wire logic                s_axis_tuser,   // [0] req_type

  // result stream
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,   // [0] carrier_on, [1] busy_res, [2] accepted

  // configuration writes
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  codes_t    codes;
  seq_res_t  seq_res;

  logic            in_valid_q, in_valid_d;
  logic            in_req_q, in_req_d;
  logic [CmdW-1:0] in_cmd_q, in_cmd_d;
  logic            out_valid_q, out_valid_d;
  seq_res_t        out_res_q, out_res_d;

  logic            step;
  logic            take;

  assign cfg_ready_o = 1'b1;

  rcpws_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .codes_o    (codes)
  );

  // a buffered request moves on when the result register is free
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign take          = s_axis_tvalid && s_axis_tready;

  rcpws_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (step),
    .req_type_i (in_req_q),
    .command_i  (in_cmd_q),
    .codes_i    (codes),
    .res_o      (seq_res)
  );

  // input register
  always_comb begin
    in_req_d   = in_req_q;
    in_cmd_d   = in_cmd_q;
    in_valid_d = step ? 1'b0 : in_valid_q;
    if (take) begin
      in_valid_d = 1'b1;
      in_req_d   = s_axis_tuser;
      in_cmd_d   = s_axis_tdata[CmdW-1:0];
    end
  end

  // result register
  always_comb begin
    out_res_d   = out_res_q;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_res_d   = seq_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_req_q  <= in_req_d;
    in_cmd_q  <= in_cmd_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 3){1'b0}}, out_res_q.accepted,
                          out_res_q.busy_res, out_res_q.carrier_on};

endmodule

`default_nettype wire

@@ sim/tb_remote_code_pulse_width_sender.sv @@
`timescale 1ns / 100ps

module tb_remote_code_pulse_width_sender;
  import rcpws_pkg::*;

  localparam int unsigned ClkPeriod  = 12;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned ItemTarget = 1150;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdlePct    = 18;

  // command code that the block must turn away
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  // where the sequencer stands within a unit
  typedef enum logic [1:0] {
    SlotMark    = 2'd0,
    SlotSpace   = 2'd1,
    SlotEndMark = 2'd2,
    SlotGap     = 2'd3
  } slot_e;

  // one row of the directed stimulus
  typedef struct packed {
    logic            kind;
    logic [CmdW-1:0] cmd;
    logic            typed;
    seq_res_t        want;
  } dir_row_t;

  localparam int unsigned DirRows = 20;

  localparam seq_res_t ResIdle    = '{carrier_on: 1'b0, busy_res: 1'b0, accepted: 1'b0};
  localparam seq_res_t ResTaken   = '{carrier_on: 1'b0, busy_res: 1'b1, accepted: 1'b1};
  localparam seq_res_t ResRefused = '{carrier_on: 1'b0, busy_res: 1'b1, accepted: 1'b0};
  localparam seq_res_t ResMark    = '{carrier_on: 1'b1, busy_res: 1'b1, accepted: 1'b0};

  // reset codes: up word starts with a one bit, so mark 1 then space 3
  localparam dir_row_t DirectedRows [DirRows] = '{
    '{ReqTick,  CmdUnused, 1'b1, ResIdle},
    '{ReqStart, CmdUnused, 1'b1, ResIdle},
    '{ReqTick,  CmdUp,     1'b1, ResIdle},
    '{ReqStart, CmdUp,     1'b1, ResTaken},
    '{ReqStart, CmdDown,   1'b1, ResRefused},
    '{ReqStart, CmdStop,   1'b1, ResRefused},
    '{ReqStart, CmdUnused, 1'b1, ResRefused},
    '{ReqTick,  CmdStop,   1'b1, ResMark},
    '{ReqTick,  CmdUnused, 1'b1, ResRefused},
    '{ReqTick,  CmdUp,     1'b1, ResRefused},
    '{ReqTick,  CmdDown,   1'b1, ResRefused},
    '{ReqTick,  CmdUp,     1'b0, ResIdle},
    '{ReqTick,  CmdUp,     1'b0, ResIdle},
    '{ReqStart, CmdStop,   1'b0, ResIdle},
    '{ReqTick,  CmdUp,     1'b0, ResIdle},
    '{ReqTick,  CmdUnused, 1'b0, ResIdle},
    '{ReqTick,  CmdUp,     1'b0, ResIdle},
    '{ReqTick,  CmdDown,   1'b0, ResIdle},
    '{ReqTick,  CmdUp,     1'b0, ResIdle},
    '{ReqTick,  CmdUp,     1'b0, ResIdle}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [1:0] command
  logic                s_axis_tuser;   // [0] req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] carrier_on, [1] busy_res, [2] accepted
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  // sequencer copy used for prediction
  codes_t              code_regs;
  logic                seq_active;
  logic [FrameW-1:0]   frame_no;
  logic [BitPosW-1:0]  bit_cnt;
  slot_e               slot;
  logic [UnitsW-1:0]   units_left;
  logic [CfgW-1:0]     shift_reg;
  logic [CfgW-1:0]     latched_code;

  seq_res_t            awaited_results[$];
  logic                no_idle;
  int unsigned         error_count;
  int unsigned         cycle_count;
  int unsigned         requests_sent;
  int unsigned         sequences_sent;
  int unsigned         starts_refused;
  int unsigned         ticks_sent;
  int unsigned         code_settings;

  remote_code_pulse_width_sender u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // load a word and set up its first bit mark
  function automatic void load_frame(input logic [CfgW-1:0] word);
    shift_reg  = word;
    bit_cnt    = '0;
    slot       = SlotMark;
    units_left = word[CodeBits-1] ? UnitsW'(1) : UnitsW'(LongUnits);
  endfunction

  // one time unit of the sequencer
  function automatic void step_unit();
    if (units_left != '0) units_left = units_left - UnitsW'(1);
    if (units_left != '0) return;
    case (slot)
      SlotMark: begin
        slot       = SlotSpace;
        units_left = shift_reg[CodeBits-1] ? UnitsW'(LongUnits) : UnitsW'(1);
      end
      SlotSpace: begin
        shift_reg = shift_reg << 1;
        bit_cnt   = bit_cnt + BitPosW'(1);
        if (bit_cnt >= BitPosW'(CodeBits)) begin
          slot       = SlotEndMark;
          units_left = UnitsW'(1);
        end else begin
          slot       = SlotMark;
          units_left = shift_reg[CodeBits-1] ? UnitsW'(1) : UnitsW'(LongUnits);
        end
      end
      SlotEndMark: begin
        if (frame_no < FrameW'(LastFrame)) begin
          slot       = SlotGap;
          units_left = UnitsW'(GapUnits);
        end else begin
          seq_active = 1'b0;
          frame_no   = '0;
          bit_cnt    = '0;
          slot       = SlotMark;
          units_left = '0;
          shift_reg  = '0;
        end
      end
      default: begin
        frame_no = frame_no + FrameW'(1);
        load_frame((frame_no >= FrameW'(LastFrame)) ? code_regs.verify_code : latched_code);
      end
    endcase
  endfunction

  // result that one accepted request should give
  function automatic seq_res_t predict_unit_result(input logic kind, input logic [CmdW-1:0] cmd);
    seq_res_t res;
    res = ResIdle;
    if (kind == ReqStart) begin
      if (!seq_active && (cmd == CmdUp || cmd == CmdDown || cmd == CmdStop)) begin
        case (cmd)
          CmdUp:   latched_code = code_regs.up_code;
          CmdDown: latched_code = code_regs.down_code;
          default: latched_code = code_regs.stop_code;
        endcase
        seq_active   = 1'b1;
        frame_no     = '0;
        load_frame(latched_code);
        res.accepted = 1'b1;
        sequences_sent++;
      end else begin
        starts_refused++;
      end
    end else begin
      ticks_sent++;
      if (seq_active) begin
        res.carrier_on = (slot == SlotMark || slot == SlotEndMark);
        step_unit();
      end
    end
    res.busy_res = seq_active;
    return res;
  endfunction

  // send one request; the typed expectation wins over the prediction if given
  task automatic push_request(input logic kind, input logic [CmdW-1:0] cmd,
                              input logic typed = 1'b0, input seq_res_t want = ResIdle);
    seq_res_t res;
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(InDataW - CmdW){1'b0}}, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_unit_result(kind, cmd);
    awaited_results.push_back(typed ? want : res);
    requests_sent++;
  endtask

  // tick until the sequence ends or the request target is met, with stray starts mixed in
  task automatic run_to_idle();
    while (seq_active && requests_sent < ItemTarget) begin
      if ($urandom_range(0, 99) < 4) push_request(ReqStart, CmdW'($urandom_range(0, 3)));
      else push_request(ReqTick, CmdW'($urandom_range(0, 3)));
    end
  endtask

  // write all four code words; block must be idle
  task automatic write_codes(input codes_t codes);
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    val;
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      idx = CfgIdxW'(i);
      case (idx)
        CfgUpCode:   val = codes.up_code;
        CfgDownCode: val = codes.down_code;
        CfgStopCode: val = codes.stop_code;
        default:     val = codes.verify_code;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CfgUpCode:   code_regs.up_code     = val;
        CfgDownCode: code_regs.down_code   = val;
        CfgStopCode: code_regs.stop_code   = val;
        default:     code_regs.verify_code = val;
      endcase
    end
    cfg_valid_i <= 1'b0;
    code_settings++;
  endtask

  task automatic report_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      error_count++;
    end
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    seq_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing expected, got tdata %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        report_field("carrier_on", want.carrier_on, m_axis_tdata[0]);
        report_field("busy_res", want.busy_res, m_axis_tdata[1]);
        report_field("accepted", want.accepted, m_axis_tdata[2]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("remote_code_pulse_width_sender test failed");
      $finish;
    end
  end

  initial begin
    codes_t      codes;
    logic [CmdW-1:0] cmd;
    int unsigned phase_idx;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= ReqTick;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgUpCode;
    cfg_data_i    <= '0;
    no_idle       <= 1'b0;
    cycle_count   = 0;
    error_count   = 0;
    requests_sent = 0;
    sequences_sent = 0;
    starts_refused = 0;
    ticks_sent    = 0;
    code_settings = 0;

    code_regs = '{up_code: UpCodeRst, down_code: DownCodeRst,
                  stop_code: StopCodeRst, verify_code: VerifyCodeRst};
    seq_active   = 1'b0;
    frame_no     = '0;
    bit_cnt      = '0;
    slot         = SlotMark;
    units_left   = '0;
    shift_reg    = '0;
    latched_code = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset code words, then finish that sequence
    for (int r = 0; r < DirRows; r++) begin
      push_request(DirectedRows[r].kind, DirectedRows[r].cmd,
                   DirectedRows[r].typed, DirectedRows[r].want);
    end
    run_to_idle();

    // random part: one full sequence per code setting
    phase_idx = 0;
    while (requests_sent < ItemTarget) begin
      case (phase_idx)
        0: begin
          codes = '{up_code: '0, down_code: '1, stop_code: CfgW'($urandom), verify_code: '1};
          cmd   = CmdUp;
        end
        1: begin
          codes = '{up_code: '1, down_code: '0, stop_code: CfgW'($urandom), verify_code: '0};
          cmd   = CmdDown;
        end
        default: begin
          codes = '{up_code: CfgW'($urandom), down_code: CfgW'($urandom),
                    stop_code: CfgW'($urandom), verify_code: CfgW'($urandom)};
          cmd   = (phase_idx == 2) ? CmdStop : CmdW'($urandom_range(0, 2));
        end
      endcase
      write_codes(codes);
      // one setting runs with both sides flat out
      no_idle <= (phase_idx == 1);
      repeat ($urandom_range(0, 3)) push_request(ReqTick, CmdW'($urandom_range(0, 3)));
      if ($urandom_range(0, 1) == 1) push_request(ReqStart, CmdUnused);
      push_request(ReqStart, cmd);
      run_to_idle();
      phase_idx++;
    end
    s_axis_tvalid <= 1'b0;
    no_idle       <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d requests: %0d sequences started, %0d starts turned away, %0d ticks",
             requests_sent, sequences_sent, starts_refused, ticks_sent);
    $display("ran %0d code word settings besides the reset values, %0d errors",
             code_settings, error_count);
    if (error_count == 0) begin
      $display("remote_code_pulse_width_sender test passed");
    end else begin
      $display("remote_code_pulse_width_sender test failed");
    end
    $finish;
  end

endmodule
